>>> hdl/priority_deque_with_cancel_assert.svh
// assertion macros for the priority deque checker
// needs a clk and an active-low rst_n in the scope that uses them
`ifndef PRIORITY_DEQUE_WITH_CANCEL_ASSERT_SVH
`define PRIORITY_DEQUE_WITH_CANCEL_ASSERT_SVH

// same-cycle implication
`define PDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pdq_pkg.sv
// shared types and constants for the priority deque
// no dependencies
package pdq_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;
    localparam int OCC_W    = 7;

    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_CANCEL   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] order_id;
        logic            quick;
    } pdq_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  removed_id;
        logic [ID_W-1:0]  front_id;
        logic             is_empty;
        logic [OCC_W-1:0] occupancy;
    } pdq_rsp_t;

endpackage

>>> hdl/priority_deque_with_cancel.sv
// priority deque with cancel, top level
// depends on pdq_pkg
//
// req channel (valid/ready) carries one operation item: add at front or rear,
// dispatch the front entry, or cancel the first entry with a matching id.
// rsp channel (valid/ready) returns exactly one item per request, in order.
// entries live in a doubly linked list held in three single-port-read
// memories (ids, forward links, backward links) with a registered read port.
// each item passes through the states in order: add writes the entry; dispatch
// and cancel scan from the front entry, unlink the hit and, when the front goes
// and others remain, read the new front id; a miss scans every entry; a rejected
// or unused operation goes straight to the output register.
// one item is worked on at a time; the next is taken the cycle after the
// current result sits in the output register, even while that result is stalled.
// a stalled receiver holds the result; a finished item then waits for the
// output register before the block goes idle again.
// reset empties the queue at once (slot flags are flip-flops), no clear pass.
module priority_deque_with_cancel (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pdq_pkg::pdq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pdq_pkg::pdq_rsp_t rsp
);
    import pdq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_FRONT  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [ID_W-1:0]   id_mem   [CAPACITY];
    logic [SLOT_W-1:0] next_mem [CAPACITY];
    logic [SLOT_W-1:0] prev_mem [CAPACITY];

    logic [2:0]          state_reg, state_next;
    logic [CAPACITY-1:0] used_reg;
    logic [SLOT_W-1:0]   front_reg, rear_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ID_W-1:0]     front_id_reg;

    logic [1:0]          kind_reg;
    logic [ID_W-1:0]     id_reg;
    logic                quick_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [COUNT_W-1:0]  step_reg;
    logic [1:0]          status_reg;
    logic [ID_W-1:0]     removed_reg;

    logic [ID_W-1:0]     id_rd_reg;
    logic [SLOT_W-1:0]   next_rd_reg, prev_rd_reg;

    logic                rsp_valid_reg;
    pdq_rsp_t            rsp_reg;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                id_we, nx_we, pv_we;
    logic [SLOT_W-1:0]   id_wa, nx_wa, pv_wa;
    logic [SLOT_W-1:0]   nx_wd, pv_wd;
    logic [SLOT_W-1:0]   free_slot;
    logic                accept, hit, last_step, out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign hit       = (kind_reg == KIND_DISPATCH) || (id_rd_reg == id_reg);
    assign last_step = (COUNT_W'(step_reg + 1'b1) == count_reg);

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = front_reg;
        id_we   = 1'b0;
        id_wa   = slot_reg;
        nx_we   = 1'b0;
        nx_wa   = slot_reg;
        nx_wd   = front_reg;
        pv_we   = 1'b0;
        pv_wa   = slot_reg;
        pv_wd   = rear_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = accept;
                rd_addr = front_reg;
            end
            S_ADD:
            begin
                id_we = 1'b1;
                if (count_reg != '0)
                begin
                    if (quick_reg)
                    begin
                        nx_we = 1'b1;
                        nx_wa = slot_reg;
                        nx_wd = front_reg;
                        pv_we = 1'b1;
                        pv_wa = front_reg;
                        pv_wd = slot_reg;
                    end
                    else
                    begin
                        pv_we = 1'b1;
                        pv_wa = slot_reg;
                        pv_wd = rear_reg;
                        nx_we = 1'b1;
                        nx_wa = rear_reg;
                        nx_wd = slot_reg;
                    end
                end
            end
            S_SCAN:
            begin
                if (!hit && !last_step)
                begin
                    rd_en   = 1'b1;
                    rd_addr = next_rd_reg;
                end
            end
            S_UNLINK:
            begin
                if (cur_reg == front_reg && cur_reg != rear_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = next_rd_reg;
                end
                else if (cur_reg != front_reg && cur_reg != rear_reg)
                begin
                    nx_we = 1'b1;
                    nx_wa = prev_rd_reg;
                    nx_wd = next_rd_reg;
                    pv_we = 1'b1;
                    pv_wa = next_rd_reg;
                    pv_wd = prev_rd_reg;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            id_rd_reg   <= id_mem[rd_addr];
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_wa] <= id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_ADD:
                        begin
                            state_next = (count_reg == COUNT_W'(CAPACITY)) ? S_FINISH : S_ADD;
                        end
                        KIND_DISPATCH, KIND_CANCEL:
                        begin
                            state_next = (count_reg == '0) ? S_FINISH : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_UNLINK;
                end
                else if (last_step)
                begin
                    state_next = S_FINISH;
                end
            end
            S_UNLINK:
            begin
                state_next = (cur_reg == front_reg && cur_reg != rear_reg) ? S_FRONT : S_FINISH;
            end
            S_FRONT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath that needs no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg    <= req.kind;
                    id_reg      <= req.order_id;
                    quick_reg   <= req.quick;
                    slot_reg    <= free_slot;
                    cur_reg     <= front_reg;
                    step_reg    <= '0;
                    removed_reg <= '0;
                    status_reg  <= ST_OK;
                    case (req.kind)
                        KIND_ADD:
                        begin
                            if (count_reg == COUNT_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                            end
                        end
                        KIND_DISPATCH, KIND_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_reg <= ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!hit)
                begin
                    if (last_step)
                    begin
                        status_reg <= ST_NOT_FOUND;
                    end
                    else
                    begin
                        cur_reg  <= next_rd_reg;
                        step_reg <= COUNT_W'(step_reg + 1'b1);
                    end
                end
            end
            S_UNLINK:
            begin
                removed_reg <= id_rd_reg;
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            front_reg    <= '0;
            rear_reg     <= '0;
            count_reg    <= '0;
            front_id_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_ADD:
                begin
                    used_reg[slot_reg] <= 1'b1;
                    count_reg          <= COUNT_W'(count_reg + 1'b1);
                    if (count_reg == '0)
                    begin
                        front_reg    <= slot_reg;
                        rear_reg     <= slot_reg;
                        front_id_reg <= id_reg;
                    end
                    else if (quick_reg)
                    begin
                        front_reg    <= slot_reg;
                        front_id_reg <= id_reg;
                    end
                    else
                    begin
                        rear_reg <= slot_reg;
                    end
                end
                S_UNLINK:
                begin
                    used_reg[cur_reg] <= 1'b0;
                    count_reg         <= COUNT_W'(count_reg - 1'b1);
                    if (cur_reg == front_reg && cur_reg == rear_reg)
                    begin
                        front_reg <= '0;
                        rear_reg  <= '0;
                    end
                    else if (cur_reg == front_reg)
                    begin
                        front_reg <= next_rd_reg;
                    end
                    else if (cur_reg == rear_reg)
                    begin
                        rear_reg <= prev_rd_reg;
                    end
                end
                S_FRONT:
                begin
                    front_id_reg <= id_rd_reg;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FINISH && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && out_free)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.removed_id <= removed_reg;
            rsp_reg.front_id   <= (count_reg == '0) ? '0 : front_id_reg;
            rsp_reg.is_empty   <= (count_reg == '0);
            rsp_reg.occupancy  <= OCC_W'(count_reg);
        end
    end

endmodule

>>> hdl/pdq_checker.sv
// port-level checks for the priority deque, bound to the top level
// depends on pdq_pkg and priority_deque_with_cancel_assert.svh
`include "priority_deque_with_cancel_assert.svh"

module pdq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input pdq_pkg::pdq_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input pdq_pkg::pdq_rsp_t rsp
);
    import pdq_pkg::*;

    `PDQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp item changed while stalled")
    `PDQ_ASSERT_IMP(a_empty_view, rsp_valid && rsp.is_empty, rsp.occupancy == '0 && rsp.front_id == '0, "empty result shows entries")
    `PDQ_ASSERT_IMP(a_full_drop, rsp_valid && rsp.status == ST_FULL, rsp.occupancy == OCC_W'(CAPACITY) && rsp.removed_id == '0, "full status with room left")
    `PDQ_ASSERT_IMP(a_no_removal, rsp_valid && (rsp.status == ST_EMPTY || rsp.status == ST_NOT_FOUND), rsp.removed_id == '0 && (rsp.status != ST_EMPTY || rsp.is_empty), "failed removal reports an id")

endmodule

bind priority_deque_with_cancel pdq_checker u_pdq_checker (.*);
